FILE: hdl/sparse_row_gather_mac_assert.svh
`ifndef SPARSE_ROW_GATHER_MAC_ASSERT_SVH
`define SPARSE_ROW_GATHER_MAC_ASSERT_SVH
// Assertion macros
`define SRG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SRG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/srgm_pkg.sv
package srgm_pkg;
    localparam int VEC_DEPTH_D = 65536;
    localparam int NNZ_DEPTH_D = 4096;
    localparam int INV_DEPTH_D = 65536;
    localparam int MAX_LEFT_D  = 256;
    localparam int MAX_RIGHT_D = 256;
    localparam int MAX_SITE_D  = 16;

    typedef enum logic [2:0] {
        OP_VEC     = 3'd0,
        OP_ROW     = 3'd1,
        OP_NZ      = 3'd2,
        OP_INV     = 3'd3,
        OP_PLEFT   = 3'd4,
        OP_PSITE   = 3'd5,
        OP_COMPUTE = 3'd6,
        OP_NONE    = 3'd7
    } opcode_t;

    localparam logic [1:0] REG_SIGN  = 2'd0;
    localparam logic [1:0] REG_RIGHT = 2'd1;
    localparam logic [1:0] REG_SITE  = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] write_addr;
        logic [31:0] load_value;
        logic [16:0] load_index;
        logic        load_parity;
        logic [7:0]  left_state;
        logic [3:0]  mid_state;
        logic [7:0]  right_state;
        logic [3:0]  rl_state;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW0,
        ST_ROW1,
        ST_NZ,
        ST_COL,
        ST_IDX,
        ST_INV,
        ST_VEC,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } state_t;
endpackage

FILE: hdl/srgm_ram.sv
module srgm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/srgm_queue.sv
module srgm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  srgm_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output srgm_pkg::item_t  out_item
);
    srgm_pkg::item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

FILE: hdl/srgm_engine.sv
module srgm_engine #(
    parameter int VEC_DEPTH = srgm_pkg::VEC_DEPTH_D,
    parameter int NNZ_DEPTH = srgm_pkg::NNZ_DEPTH_D,
    parameter int INV_DEPTH = srgm_pkg::INV_DEPTH_D,
    parameter int MAX_LEFT  = srgm_pkg::MAX_LEFT_D,
    parameter int MAX_RIGHT = srgm_pkg::MAX_RIGHT_D,
    parameter int MAX_SITE  = srgm_pkg::MAX_SITE_D
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  srgm_pkg::item_t q_item,
    input  logic            sign_enable,
    input  logic [8:0]      dim_right,
    input  logic [4:0]      dim_site,
    output logic            res_valid,
    input  logic            res_ready,
    output logic [63:0]     out_value,
    output logic            saturated
);
    localparam int VAW = $clog2(VEC_DEPTH);
    localparam int NAW = $clog2(NNZ_DEPTH);
    localparam int IAW = $clog2(INV_DEPTH);
    localparam int RAW = $clog2(MAX_RIGHT + 1);
    localparam int LAW = $clog2(MAX_LEFT);
    localparam int SAW = $clog2(MAX_SITE);
    localparam int PW  = NAW + 1;

    srgm_pkg::state_t state_reg, state_next;
    srgm_pkg::item_t  it_reg;
    logic [PW-1:0]    k_reg, end_reg;
    logic             neg_reg;
    logic [63:0]      acc_reg;
    logic             clip_reg;
    logic [39:0]      idx_reg;
    logic [63:0]      prod_reg;
    logic             ovalid_reg;
    logic [63:0]      oval_reg;
    logic             osat_reg;

    logic             take;
    srgm_pkg::opcode_t op;
    logic             is_load;

    logic [PW-1:0]  row_rdata, row_wdata;
    logic           row_we;
    logic [RAW-1:0] row_raddr;
    logic [16:0]    col_rdata;
    logic [31:0]    nzv_rdata, vec_rdata;
    logic [16:0]    inv_rdata;
    logic [0:0]     pl_rdata, ps_rdata;
    logic [IAW-1:0] inv_raddr;
    logic [VAW-1:0] vec_raddr;

    assign op      = srgm_pkg::opcode_t'(q_item.opcode);
    assign q_ready = (state_reg == srgm_pkg::ST_IDLE);
    assign take    = q_valid && q_ready;
    assign is_load = take && (op != srgm_pkg::OP_COMPUTE);

    // row start clamp
    always_comb
    begin
        if (q_item.load_index[16])
            row_wdata = '0;
        else if ({15'd0, q_item.load_index} > 32'(NNZ_DEPTH))
            row_wdata = PW'(NNZ_DEPTH);
        else
            row_wdata = PW'(q_item.load_index);
    end
    assign row_we = is_load && op == srgm_pkg::OP_ROW
                    && 32'(q_item.write_addr) < 32'(MAX_RIGHT + 1);

    always_comb
    begin
        row_raddr = RAW'(it_reg.right_state);
        if (state_reg == srgm_pkg::ST_ROW0)
            row_raddr = RAW'({1'b0, it_reg.right_state} + 9'd1);
        if (take)
            row_raddr = RAW'(q_item.right_state);
    end

    srgm_ram #(.WIDTH(PW), .DEPTH(MAX_RIGHT + 1)) u_row (
        .clk(clk), .we(row_we), .waddr(RAW'(q_item.write_addr)), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata));

    srgm_ram #(.WIDTH(17), .DEPTH(NNZ_DEPTH)) u_col (
        .clk(clk),
        .we(is_load && op == srgm_pkg::OP_NZ && 32'(q_item.write_addr) < 32'(NNZ_DEPTH)),
        .waddr(NAW'(q_item.write_addr)), .wdata(q_item.load_index),
        .raddr(NAW'(k_reg)), .rdata(col_rdata));

    srgm_ram #(.WIDTH(32), .DEPTH(NNZ_DEPTH)) u_nzv (
        .clk(clk),
        .we(is_load && op == srgm_pkg::OP_NZ && 32'(q_item.write_addr) < 32'(NNZ_DEPTH)),
        .waddr(NAW'(q_item.write_addr)), .wdata(q_item.load_value),
        .raddr(NAW'(k_reg)), .rdata(nzv_rdata));

    assign inv_raddr = IAW'(idx_reg);
    srgm_ram #(.WIDTH(17), .DEPTH(INV_DEPTH)) u_inv (
        .clk(clk),
        .we(is_load && op == srgm_pkg::OP_INV && 32'(q_item.write_addr) < 32'(INV_DEPTH)),
        .waddr(IAW'(q_item.write_addr)), .wdata(q_item.load_index),
        .raddr(inv_raddr), .rdata(inv_rdata));

    assign vec_raddr = VAW'(inv_rdata);
    srgm_ram #(.WIDTH(32), .DEPTH(VEC_DEPTH)) u_vec (
        .clk(clk),
        .we(is_load && op == srgm_pkg::OP_VEC && 32'(q_item.write_addr) < 32'(VEC_DEPTH)),
        .waddr(VAW'(q_item.write_addr)), .wdata(q_item.load_value),
        .raddr(vec_raddr), .rdata(vec_rdata));

    srgm_ram #(.WIDTH(1), .DEPTH(MAX_LEFT)) u_pl (
        .clk(clk),
        .we(is_load && op == srgm_pkg::OP_PLEFT && 32'(q_item.write_addr) < 32'(MAX_LEFT)),
        .waddr(LAW'(q_item.write_addr)), .wdata(q_item.load_parity),
        .raddr(LAW'(q_item.left_state)), .rdata(pl_rdata));

    srgm_ram #(.WIDTH(1), .DEPTH(MAX_SITE)) u_ps (
        .clk(clk),
        .we(is_load && op == srgm_pkg::OP_PSITE && 32'(q_item.write_addr) < 32'(MAX_SITE)),
        .waddr(SAW'(q_item.write_addr)), .wdata(q_item.load_parity),
        .raddr(SAW'(q_item.mid_state)), .rdata(ps_rdata));

    logic pl_ok_reg, ps_ok_reg;
    logic row_ok_reg;
    logic [PW-1:0] beg_reg;

    // index pieces: each a register apart
    logic [39:0] t_next;
    logic [63:0] sum;
    logic        inv_ok;
    logic [39:0] ls_reg;

    assign inv_ok = !inv_rdata[16] && 32'(inv_rdata) < 32'(VEC_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srgm_pkg::ST_IDLE:
                if (take && op == srgm_pkg::OP_COMPUTE) state_next = srgm_pkg::ST_ROW0;
            srgm_pkg::ST_ROW0: state_next = srgm_pkg::ST_ROW1;
            srgm_pkg::ST_ROW1: state_next = srgm_pkg::ST_NZ;
            srgm_pkg::ST_NZ:
                if (k_reg < end_reg && k_reg < PW'(NNZ_DEPTH)) state_next = srgm_pkg::ST_COL;
                else state_next = srgm_pkg::ST_OUT;
            srgm_pkg::ST_COL: state_next = srgm_pkg::ST_IDX;
            srgm_pkg::ST_IDX:
                if (idx_reg < 40'(INV_DEPTH)) state_next = srgm_pkg::ST_INV;
                else state_next = srgm_pkg::ST_NZ;
            srgm_pkg::ST_INV:
                state_next = inv_ok ? srgm_pkg::ST_VEC : srgm_pkg::ST_NZ;
            srgm_pkg::ST_VEC: state_next = srgm_pkg::ST_MUL;
            srgm_pkg::ST_MUL: state_next = srgm_pkg::ST_ACC;
            srgm_pkg::ST_ACC: state_next = srgm_pkg::ST_NZ;
            srgm_pkg::ST_OUT:
                if (!ovalid_reg || res_ready) state_next = srgm_pkg::ST_IDLE;
            default: state_next = srgm_pkg::ST_IDLE;
        endcase
    end

    assign sum = acc_reg + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= srgm_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_valid && res_ready) ovalid_reg <= 1'b0;
            if (state_reg == srgm_pkg::ST_OUT && (!ovalid_reg || res_ready))
                ovalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            srgm_pkg::ST_IDLE:
            begin
                it_reg    <= q_item;
                pl_ok_reg <= 32'(q_item.left_state) < 32'(MAX_LEFT);
                ps_ok_reg <= 32'(q_item.mid_state) < 32'(MAX_SITE);
                row_ok_reg <= 32'(q_item.right_state) + 1 < 32'(MAX_RIGHT + 1);
                acc_reg   <= '0;
                clip_reg  <= 1'b0;
                ls_reg    <= 40'(q_item.left_state) * 40'(dim_site) + 40'(q_item.mid_state);
            end
            srgm_pkg::ST_ROW0:
            begin
                neg_reg <= sign_enable && ((pl_ok_reg & pl_rdata[0]) ^ (ps_ok_reg & ps_rdata[0]));
                beg_reg <= row_rdata;
                ls_reg  <= 40'(ls_reg[23:0] * 24'(dim_right)) ;
            end
            srgm_pkg::ST_ROW1:
            begin
                k_reg   <= row_ok_reg ? beg_reg : '0;
                end_reg <= row_ok_reg ? row_rdata : '0;
            end
            srgm_pkg::ST_NZ:
                ;
            srgm_pkg::ST_COL:
                ;
            srgm_pkg::ST_IDX:
                ;
            srgm_pkg::ST_INV:
                if (!inv_ok) k_reg <= k_reg + 1'b1;
            srgm_pkg::ST_VEC:
                ;
            srgm_pkg::ST_MUL:
            begin
                prod_reg <= neg_reg ? -($signed(vec_rdata) * $signed(nzv_rdata))
                                    :  ($signed(vec_rdata) * $signed(nzv_rdata));
            end
            srgm_pkg::ST_ACC:
            begin
                k_reg <= k_reg + 1'b1;
                if (!prod_reg[63] && !acc_reg[63] && sum[63])
                begin
                    acc_reg <= 64'h7FFF_FFFF_FFFF_FFFF; clip_reg <= 1'b1;
                end
                else if (prod_reg[63] && acc_reg[63] && !sum[63])
                begin
                    acc_reg <= 64'h8000_0000_0000_0000; clip_reg <= 1'b1;
                end
                else
                    acc_reg <= sum;
            end
            srgm_pkg::ST_OUT:
                if (!ovalid_reg || res_ready)
                begin
                    oval_reg <= acc_reg;
                    osat_reg <= clip_reg;
                end
            default: ;
        endcase
        // index: (ls*dr + col)*ds + rl, one multiply per cycle
        if (state_reg == srgm_pkg::ST_COL)
            idx_reg <= t_next;
        else if (state_reg == srgm_pkg::ST_IDX && idx_reg >= 40'(INV_DEPTH))
            k_reg <= k_reg + 1'b1;
    end

    logic [39:0] base_reg;
    // col_rdata is valid in ST_COL (address k_reg presented at the ST_NZ edge)
    always_ff @(posedge clk)
    begin
        if (state_reg == srgm_pkg::ST_ROW1)
            base_reg <= ls_reg;
    end
    // a negative index wraps in 40 bits and fails the range check
    assign t_next = (base_reg + 40'($signed(col_rdata))) * 40'(dim_site)
                    + 40'(it_reg.rl_state);

    assign res_valid = ovalid_reg;
    assign out_value = oval_reg;
    assign saturated = osat_reg;
endmodule

FILE: hdl/sparse_row_gather_mac.sv
// sparse_row_gather_mac
// Input channel (valid/ready): loads (opcodes 0..5) write one entry if in range;
// opcode 6 is a compute item returning one result; opcode 7 is dropped.
// Output channel (valid/ready): out_value (Q16.48) and saturated flag.
// APB port: reg 0 sign_enable, 1 dim_right, 2 dim_site, at 4*i.
// Items pass through a two-entry queue into a sequencer.
// A load is taken while the sequencer idles and leaves it idle. A compute walks
// ROW0, ROW1 and NZ, then per nonzero of the row COL and IDX, ending there if the
// index is out of range, INV, ending there if the inverse entry is absent, else
// VEC, MUL and ACC, adding the term; it ends in OUT, which registers the result.
// These steps follow the memory read chain row -> column -> inverse -> vector.
// The result sits in an output register; while the receiver stalls the next
// compute waits in the sequencer and the queue takes items until both entries fill.
// Reset clears control state and the registers to their reset values;
// stores hold no value until written.
module sparse_row_gather_mac #(
    parameter int VEC_DEPTH = srgm_pkg::VEC_DEPTH_D,
    parameter int NNZ_DEPTH = srgm_pkg::NNZ_DEPTH_D,
    parameter int INV_DEPTH = srgm_pkg::INV_DEPTH_D,
    parameter int MAX_LEFT  = srgm_pkg::MAX_LEFT_D,
    parameter int MAX_RIGHT = srgm_pkg::MAX_RIGHT_D,
    parameter int MAX_SITE  = srgm_pkg::MAX_SITE_D
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [15:0] write_addr,
    input  logic [31:0] load_value,
    input  logic [16:0] load_index,
    input  logic        load_parity,
    input  logic [7:0]  left_state,
    input  logic [3:0]  mid_state,
    input  logic [7:0]  right_state,
    input  logic [3:0]  rl_state,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_value,
    output logic        saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    `include "sparse_row_gather_mac_assert.svh"

    logic       sign_reg;
    logic [8:0] right_reg;
    logic [4:0] site_reg;
    logic       wr;
    srgm_pkg::item_t in_item, q_item;
    logic       q_valid, q_ready;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_reg  <= 1'b0;
            right_reg <= 9'd256;
            site_reg  <= 5'd4;
        end
        else if (wr)
        begin
            if (paddr[3:2] == srgm_pkg::REG_SIGN)  sign_reg  <= pwdata[0];
            if (paddr[3:2] == srgm_pkg::REG_RIGHT) right_reg <= pwdata[8:0];
            if (paddr[3:2] == srgm_pkg::REG_SITE)  site_reg  <= pwdata[4:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            srgm_pkg::REG_SIGN:  prdata = {31'd0, sign_reg};
            srgm_pkg::REG_RIGHT: prdata = {23'd0, right_reg};
            srgm_pkg::REG_SITE:  prdata = {27'd0, site_reg};
            default:             prdata = '0;
        endcase
    end

    assign in_item = '{opcode, write_addr, load_value, load_index, load_parity,
                       left_state, mid_state, right_state, rl_state};

    srgm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));

    srgm_engine #(
        .VEC_DEPTH(VEC_DEPTH), .NNZ_DEPTH(NNZ_DEPTH), .INV_DEPTH(INV_DEPTH),
        .MAX_LEFT(MAX_LEFT), .MAX_RIGHT(MAX_RIGHT), .MAX_SITE(MAX_SITE)
    ) u_engine (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .sign_enable(sign_reg), .dim_right(right_reg), .dim_site(site_reg),
        .res_valid(out_valid), .res_ready(out_ready),
        .out_value(out_value), .saturated(saturated));

    `SRG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value))
    `SRG_ASSERT_IMPL(a_q_full, !in_ready, q_valid)
endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srgm_pkg::*;

    typedef struct {
        logic [63:0] value;
        logic        sat;
    } sum_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    item_t       cur = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] out_value;
    logic        saturated;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    item_t pend_q[$];
    sum_t  sum_q[$];
    int    err_cnt = 0;
    int    sent_cnt = 0;
    int    hold_cnt = 0;
    bit    hold_done = 1'b0;
    int    n_effect = 0;

    bit cfg_sign = 1'b0;
    int cfg_right = 256;
    int cfg_site = 4;

    int vec_mem[VEC_DEPTH_D];
    bit vec_ok[VEC_DEPTH_D];
    int row_mem[MAX_RIGHT_D + 1];
    bit row_ok[MAX_RIGHT_D + 1];
    int col_mem[NNZ_DEPTH_D];
    int val_mem[NNZ_DEPTH_D];
    bit nz_ok[NNZ_DEPTH_D];
    int inv_mem[INV_DEPTH_D];
    bit inv_ok[INV_DEPTH_D];
    bit pl_mem[MAX_LEFT_D];
    bit pl_ok[MAX_LEFT_D];
    bit ps_mem[MAX_SITE_D];
    bit ps_ok[MAX_SITE_D];

    sparse_row_gather_mac u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(cur.opcode), .write_addr(cur.write_addr),
        .load_value(cur.load_value), .load_index(cur.load_index),
        .load_parity(cur.load_parity), .left_state(cur.left_state),
        .mid_state(cur.mid_state), .right_state(cur.right_state),
        .rl_state(cur.rl_state),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_value(out_value), .saturated(saturated),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    function automatic longint gather_index(int l, int m, int col, int r);
        return ((longint'(l) * cfg_site + m) * cfg_right + col) * cfg_site + r;
    endfunction

    function automatic sum_t row_product(item_t it);
        sum_t   s;
        longint acc;
        longint term;
        longint idx;
        int     beg;
        int     fin;
        int     e;
        bit     neg;
        bit     clip;
        acc = 0;
        clip = 1'b0;
        neg = cfg_sign && (pl_mem[it.left_state] ^ ps_mem[it.mid_state]);
        beg = row_mem[it.right_state];
        fin = row_mem[it.right_state + 1];
        for (int k = beg; k < fin && k < NNZ_DEPTH_D; k++)
        begin
            idx = gather_index(it.left_state, it.mid_state, col_mem[k], it.rl_state);
            if (idx < 0 || idx >= INV_DEPTH_D)
                continue;
            e = inv_mem[idx];
            if (e < 0 || e >= VEC_DEPTH_D)
                continue;
            term = longint'(vec_mem[e]) * longint'(val_mem[k]);
            if (neg)
                term = -term;
            if (term > 0 && acc > 64'sh7fffffffffffffff - term)
            begin
                acc = 64'sh7fffffffffffffff;
                clip = 1'b1;
            end
            else if (term < 0 && acc < $signed(64'h8000000000000000) - term)
            begin
                acc = $signed(64'h8000000000000000);
                clip = 1'b1;
            end
            else
                acc = acc + term;
        end
        s.value = acc;
        s.sat = clip;
        return s;
    endfunction

    // update stores and push the expected sum, in acceptance order
    task automatic queue_item(item_t it);
        int a;
        int ix;
        a = int'(it.write_addr);
        ix = int'($signed(it.load_index));
        case (opcode_t'(it.opcode))
            OP_VEC:
            begin
                vec_mem[a] = int'($signed(it.load_value));
                vec_ok[a] = 1'b1;
                n_effect++;
            end
            OP_ROW:
                if (a <= MAX_RIGHT_D)
                begin
                    row_mem[a] = ix < 0 ? 0 : (ix > NNZ_DEPTH_D ? NNZ_DEPTH_D : ix);
                    row_ok[a] = 1'b1;
                    n_effect++;
                end
            OP_NZ:
                if (a < NNZ_DEPTH_D)
                begin
                    col_mem[a] = ix;
                    val_mem[a] = int'($signed(it.load_value));
                    nz_ok[a] = 1'b1;
                    n_effect++;
                end
            OP_INV:
            begin
                inv_mem[a] = ix;
                inv_ok[a] = 1'b1;
                n_effect++;
            end
            OP_PLEFT:
                if (a < MAX_LEFT_D)
                begin
                    pl_mem[a] = it.load_parity;
                    pl_ok[a] = 1'b1;
                    n_effect++;
                end
            OP_PSITE:
                if (a < MAX_SITE_D)
                begin
                    ps_mem[a] = it.load_parity;
                    ps_ok[a] = 1'b1;
                    n_effect++;
                end
            OP_COMPUTE:
            begin
                sum_q.push_back(row_product(it));
                n_effect++;
            end
            default: ;
        endcase
        pend_q.push_back(it);
    endtask

    function automatic item_t rand_item();
        item_t it;
        it = item_t'(93'({$urandom, $urandom, $urandom}));
        return it;
    endfunction

    task automatic load(opcode_t op, int addr, int val, int idx, int par);
        item_t it;
        it = rand_item();
        it.opcode = op;
        it.write_addr = addr[15:0];
        it.load_value = val;
        it.load_index = idx[16:0];
        it.load_parity = par[0];
        queue_item(it);
    endtask

    task automatic compute(int l, int m, int r, int rl);
        item_t it;
        it = rand_item();
        it.opcode = OP_COMPUTE;
        it.left_state = l[7:0];
        it.mid_state = m[3:0];
        it.right_state = r[7:0];
        it.rl_state = rl[3:0];
        queue_item(it);
    endtask

    function automatic int rand_q824();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_col();
        case ($urandom_range(0, 9))
            0: return -1;
            1: return int'($signed(17'($urandom)));
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int rand_entry();
        case ($urandom_range(0, 9))
            0: return -1;
            1: return int'($signed(17'($urandom_range(65536, 131071))));
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // write whatever the walk of this row will read, then compute
    task automatic plan_compute(int l, int m, int r, int rl);
        longint idx;
        int     e;
        if (!pl_ok[l] || $urandom_range(0, 7) == 0)
            load(OP_PLEFT, l, $urandom, $urandom, $urandom);
        if (!ps_ok[m] || $urandom_range(0, 7) == 0)
            load(OP_PSITE, m, $urandom, $urandom, $urandom);
        if (!row_ok[r])
            load(OP_ROW, r, $urandom, $urandom_range(0, 4090), $urandom);
        if (!row_ok[r + 1] || $urandom_range(0, 4) == 0)
        begin
            if ($urandom_range(0, 7) == 0)
                load(OP_ROW, r + 1, $urandom, int'($signed(17'($urandom))), $urandom);
            else
                load(OP_ROW, r + 1, $urandom, row_mem[r] + $urandom_range(0, 6), $urandom);
        end
        if (row_mem[r + 1] - row_mem[r] > 8)
            load(OP_ROW, r + 1, $urandom, row_mem[r] + $urandom_range(0, 6), $urandom);
        for (int k = row_mem[r]; k < row_mem[r + 1] && k < NNZ_DEPTH_D; k++)
        begin
            if (!nz_ok[k] || $urandom_range(0, 4) == 0)
                load(OP_NZ, k, rand_q824(), rand_col(), $urandom);
            idx = gather_index(l, m, col_mem[k], rl);
            if (idx >= 0 && idx < INV_DEPTH_D)
            begin
                if (!inv_ok[idx] || $urandom_range(0, 5) == 0)
                    load(OP_INV, int'(idx), $urandom, rand_entry(), $urandom);
                e = inv_mem[idx];
                if (e >= 0 && (!vec_ok[e] || $urandom_range(0, 4) == 0))
                    load(OP_VEC, e, rand_q824(), $urandom, $urandom);
            end
        end
        compute(l, m, r, rl);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SIGN: cfg_sign = data[0];
            REG_RIGHT: cfg_right = data[8:0];
            REG_SITE: cfg_site = data[4:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pend_q.size() != 0 || in_valid || sum_q.size() != 0);
        repeat (64) @(posedge clk);
    endtask

    // sender: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                sent_cnt <= sent_cnt + 1;
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pend_q.size() != 0)
                begin
                    cur <= pend_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off while the sender keeps going
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            if (hold_cnt == 1)
                hold_done <= 1'b1;
        end
        else if (!hold_done && sent_cnt >= 300)
            hold_cnt <= 600;
    end

    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        sum_t s;
        if (rst_n && out_valid && out_ready)
        begin
            if (sum_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result %h sat %b", out_value, saturated);
            end
            else
            begin
                s = sum_q.pop_front();
                if (out_value !== s.value || saturated !== s.sat)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: expected %h sat %b, got %h sat %b",
                                 s.value, s.sat, out_value, saturated);
                end
            end
        end
        if (stall_left == 0)
        begin
            stall_left = $urandom_range(8, 64);
            stall_mode = $urandom_range(0, 2);
        end
        else
            stall_left--;
        if (!rst_n || hold_cnt != 0)
            out_ready <= 1'b0;
        else
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= $urandom_range(0, 3) == 0;
            endcase
    end

    initial
    begin
        #2_000_000;
        $display("FAIL sparse_row_gather_mac");
        $finish;
    end

    initial
    begin
        int r;
        int mode[6][3] = '{'{1, 256, 4}, '{1, 1, 1}, '{0, 16, 16},
                           '{1, 0, 0}, '{1, 3, 16}, '{0, 256, 1}};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        load(OP_NONE, 0, 0, 0, 0);
        load(OP_ROW, 257, 0, 0, 0);
        load(OP_ROW, 65535, 0, 0, 0);
        load(OP_NZ, 4096, 0, 0, 0);
        load(OP_PLEFT, 256, 0, 0, 1);
        load(OP_PSITE, 16, 0, 0, 1);
        load(OP_PLEFT, 0, 0, 0, 1);
        load(OP_PLEFT, 255, 0, 0, 0);
        load(OP_PSITE, 0, 0, 0, 0);
        load(OP_PSITE, 15, 0, 0, 1);
        // two extreme products overflow the sum
        load(OP_ROW, 0, 0, -5, 0);
        load(OP_ROW, 1, 0, 2, 0);
        load(OP_NZ, 0, 32'h80000000, 0, 0);
        load(OP_NZ, 1, 32'h80000000, 1, 0);
        load(OP_INV, 0, 0, 10, 0);
        load(OP_INV, 4, 0, 11, 0);
        load(OP_VEC, 10, 32'h80000000, 0, 0);
        load(OP_VEC, 11, 32'h80000000, 0, 0);
        compute(0, 0, 0, 0);
        // clamped start, empty row at the top, inverted row
        load(OP_ROW, 255, 0, 65535, 0);
        load(OP_ROW, 256, 0, 4096, 0);
        compute(255, 15, 255, 15);
        load(OP_ROW, 2, 0, 1, 0);
        compute(0, 0, 1, 0);
        // negative index, index past the table, absent inverse entry
        load(OP_ROW, 3, 0, 2, 0);
        load(OP_ROW, 4, 0, 5, 0);
        load(OP_NZ, 2, 32'h01000000, -1, 0);
        load(OP_NZ, 3, 32'h01000000, 65535, 0);
        load(OP_NZ, 4, 32'h01000000, 2, 0);
        load(OP_INV, 8, 0, -1, 0);
        compute(0, 0, 3, 0);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            apb_write(REG_SIGN, mode[p][0]);
            apb_write(REG_RIGHT, mode[p][1]);
            apb_write(REG_SITE, mode[p][2]);
            n_effect = 0;
            while (n_effect < 250)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    plan_compute($urandom_range(0, 2) != 0 ? $urandom_range(0, 3)
                                                         : $urandom_range(0, 255),
                                 $urandom_range(0, 15), $urandom_range(0, 255),
                                 $urandom_range(0, 15));
                else if (r < 97)
                    load(opcode_t'($urandom_range(0, 5)),
                         $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 65535),
                         rand_q824(), int'($signed(17'($urandom))), $urandom);
                else
                    load(OP_NONE, $urandom, $urandom, $urandom, $urandom);
            end
            drain();
        end

        if (err_cnt == 0 && sum_q.size() == 0)
            $display("PASS sparse_row_gather_mac");
        else
            $display("FAIL sparse_row_gather_mac");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/srgm_pkg.sv
hdl/srgm_ram.sv
hdl/srgm_queue.sv
hdl/srgm_engine.sv
hdl/sparse_row_gather_mac.sv
tb/tb.sv
